[rtl/tkcs_pkg.sv]
// Shared types, constants and codes of the top-k cosine vector search block
package tkcs_pkg;

	localparam int CAPACITY = 256;
	localparam int MAX_DIM  = 64;
	localparam int MAX_K    = 16;

	localparam int EL_W    = 16;
	localparam int ID_W    = 32;
	localparam int OP_W    = 2;
	localparam int ST_W    = 3;
	localparam int RANK_W  = 4;
	localparam int LEN_W   = 7;
	localparam int LIM_W   = 5;
	localparam int SLOT_W  = $clog2(CAPACITY);
	localparam int CNT_W   = SLOT_W + 1;
	localparam int DIM_W   = $clog2(MAX_DIM);
	localparam int K_W     = $clog2(MAX_K);
	localparam int KC_W    = K_W + 1;
	localparam int VS_AW   = $clog2(CAPACITY * MAX_DIM);
	localparam int PROD_W  = 2 * EL_W;
	localparam int ACC_W   = PROD_W - 1 + DIM_W;
	localparam int DOT_W   = ACC_W + 1;
	localparam int SQ_W    = 2 * ACC_W;
	localparam int FRAC_SH = 2 * (EL_W - 1);
	localparam int RHS_W   = SQ_W + FRAC_SH;
	localparam int WIDE_W  = SQ_W + 2 * EL_W + 1;
	localparam int ROOT_W  = EL_W;
	localparam int BIT_W   = $clog2(ROOT_W);
	localparam int MCNT_W  = $clog2(ACC_W);
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 32;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		STS_INSERTED  = 3'd0,
		STS_FULL      = 3'd1,
		STS_REMOVED   = 3'd2,
		STS_NOT_FOUND = 3'd3,
		STS_MATCH     = 3'd4,
		STS_EMPTY     = 3'd5
	} status_t;

	typedef enum logic {
		REG_VLEN = 1'b0
	} reg_idx_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_RESP,
		T_RM_RD,
		T_RM_CMP,
		T_Q_NEXT,
		T_Q_SCORE,
		T_EMIT
	} top_state_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_MAC,
		SC_CHK,
		SC_MUL,
		SC_ROOT,
		SC_DONE
	} sc_state_t;

	typedef struct packed {
		logic [OP_W-1:0]        opcode;
		logic [ID_W-1:0]        entry_id;
		logic signed [EL_W-1:0] element;
		logic [LIM_W-1:0]       result_limit;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]        status;
		logic [ID_W-1:0]        match_id;
		logic signed [EL_W-1:0] similarity;
		logic [RANK_W-1:0]      rank;
		logic                   last_result;
	} rsp_t;

	typedef struct packed {
		logic                   en;
		logic                   store;
		logic [SLOT_W-1:0]      slot;
		logic [DIM_W-1:0]       pos;
		logic signed [EL_W-1:0] data;
	} elem_wr_t;

	typedef struct packed {
		logic              start;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
	} score_req_t;

	typedef struct packed {
		logic             clr;
		logic             ins;
		logic [LIM_W-1:0] limit;
	} topk_ctl_t;

endpackage

[rtl/tkcs_score.sv]
// Vector stores and iterative cosine score unit: shared multiplier, serial products, bitwise root
module tkcs_score (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tkcs_pkg::elem_wr_t                    wr,
	input  tkcs_pkg::score_req_t                  sreq,
	output logic                                  done,
	output logic signed [tkcs_pkg::EL_W-1:0]      score
);
	import tkcs_pkg::*;

	logic signed [EL_W-1:0] qbuf [MAX_DIM];
	logic signed [EL_W-1:0] vstore [CAPACITY*MAX_DIM];

	sc_state_t state_q, state_d;
	logic [SLOT_W-1:0]        slot_q;
	logic [LEN_W-1:0]         len_q;
	logic [DIM_W-1:0]         e_q;
	logic [2:0]               ph_q;
	logic signed [EL_W-1:0]   qd_q, vd_q;
	logic signed [PROD_W-1:0] mp_q;
	logic signed [DOT_W-1:0]  dot_q;
	logic [ACC_W-1:0]         nq_q, nv_q;
	logic [SQ_W-1:0]          sa_q, pa_q, rhs_raw_q, prod_q;
	logic [ACC_W-1:0]         sb_q, pb_q;
	logic [MCNT_W-1:0]        mcnt_q;
	logic                     neg_q;
	logic [BIT_W-1:0]         b_q;
	logic [1:0]               rph_q;
	logic [ROOT_W-1:0]        x_q;
	logic [WIDE_W-1:0]        t_q, u_q, tmp_q, cand_q;

	logic [VS_AW-1:0]       wr_addr, rd_addr;
	logic signed [EL_W-1:0] ma, mb;
	logic [ACC_W-1:0]       mag;
	logic                   last_el;
	logic [RHS_W-1:0]       rhs;
	logic [WIDE_W-1:0]      pshift;

	assign wr_addr = VS_AW'(wr.slot) * VS_AW'(MAX_DIM) + VS_AW'(wr.pos);
	assign rd_addr = VS_AW'(slot_q) * VS_AW'(MAX_DIM) + VS_AW'(e_q);

	always_ff @(posedge clk) begin
		if (wr.en)
			qbuf[wr.pos] <= wr.data;
		if (wr.en && wr.store)
			vstore[wr_addr] <= wr.data;
		qd_q <= qbuf[e_q];
		vd_q <= vstore[rd_addr];
	end

	// phase 1: q*v, phase 2: q*q, phase 3: v*v
	assign ma = (ph_q == 3'd3) ? vd_q : qd_q;
	assign mb = (ph_q == 3'd1 || ph_q == 3'd3) ? vd_q : qd_q;

	assign mag     = ACC_W'(dot_q[DOT_W-1] ? -dot_q : dot_q);
	assign last_el = (LEN_W'(e_q) + LEN_W'(1)) == len_q;
	assign rhs     = {rhs_raw_q, {FRAC_SH{1'b0}}};
	assign pshift  = WIDE_W'(prod_q) << b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SC_IDLE: begin
				if (sreq.start)
					state_d = SC_MAC;
			end
			SC_MAC: begin
				if (ph_q == 3'd4 && last_el)
					state_d = SC_CHK;
			end
			SC_CHK: begin
				if (nq_q == '0 || nv_q == '0)
					state_d = SC_DONE;
				else
					state_d = SC_MUL;
			end
			SC_MUL: begin
				if (mcnt_q == MCNT_W'(ACC_W - 1))
					state_d = SC_ROOT;
			end
			SC_ROOT: begin
				if (rph_q == 2'd2 && b_q == '0)
					state_d = SC_DONE;
			end
			SC_DONE: begin
				state_d = SC_IDLE;
			end
			default: state_d = SC_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		mp_q <= ma * mb;
		case (state_q)
			SC_IDLE: begin
				if (sreq.start) begin
					slot_q <= sreq.slot;
					len_q  <= sreq.len;
					e_q    <= '0;
					ph_q   <= '0;
					dot_q  <= '0;
					nq_q   <= '0;
					nv_q   <= '0;
				end
			end
			SC_MAC: begin
				case (ph_q)
					3'd2: dot_q <= dot_q + DOT_W'(mp_q);
					3'd3: nq_q <= nq_q + ACC_W'(mp_q[PROD_W-2:0]);
					3'd4: nv_q <= nv_q + ACC_W'(mp_q[PROD_W-2:0]);
					default: ;
				endcase
				if (ph_q == 3'd4) begin
					ph_q <= '0;
					if (!last_el)
						e_q <= e_q + DIM_W'(1);
				end else begin
					ph_q <= ph_q + 3'd1;
				end
			end
			SC_CHK: begin
				x_q       <= '0;
				neg_q     <= dot_q[DOT_W-1];
				sa_q      <= SQ_W'(mag);
				sb_q      <= mag;
				pa_q      <= SQ_W'(nq_q);
				pb_q      <= nv_q;
				rhs_raw_q <= '0;
				prod_q    <= '0;
				mcnt_q    <= '0;
			end
			SC_MUL: begin
				if (sb_q[0])
					rhs_raw_q <= rhs_raw_q + sa_q;
				if (pb_q[0])
					prod_q <= prod_q + pa_q;
				sa_q   <= sa_q << 1;
				sb_q   <= sb_q >> 1;
				pa_q   <= pa_q << 1;
				pb_q   <= pb_q >> 1;
				mcnt_q <= mcnt_q + MCNT_W'(1);
				b_q    <= BIT_W'(ROOT_W - 1);
				rph_q  <= '0;
				t_q    <= '0;
				u_q    <= '0;
			end
			SC_ROOT: begin
				// t = x^2*P, u = x*P; trial (x+2^b)^2*P = t + 2^b*(2u + 2^b*P)
				case (rph_q)
					2'd0: begin
						tmp_q <= (u_q << 1) + pshift;
						rph_q <= 2'd1;
					end
					2'd1: begin
						cand_q <= t_q + (tmp_q << b_q);
						rph_q  <= 2'd2;
					end
					default: begin
						if (cand_q <= WIDE_W'(rhs)) begin
							t_q      <= cand_q;
							u_q      <= u_q + pshift;
							x_q[b_q] <= 1'b1;
						end
						b_q   <= b_q - BIT_W'(1);
						rph_q <= 2'd0;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign done = (state_q == SC_DONE);

	always_comb begin
		if (neg_q)
			score = EL_W'(-{1'b0, x_q});
		else if (x_q[ROOT_W-1])
			score = {1'b0, {(EL_W-1){1'b1}}};
		else
			score = EL_W'(x_q);
	end

endmodule

[rtl/tkcs_topk.sv]
// Sorted best-k list with parallel shift insertion and indexed read-out
module tkcs_topk (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tkcs_pkg::topk_ctl_t                   ctl,
	input  logic signed [tkcs_pkg::EL_W-1:0]      score,
	input  logic [tkcs_pkg::ID_W-1:0]             tag,
	input  logic [tkcs_pkg::K_W-1:0]              rd_idx,
	output logic [tkcs_pkg::KC_W-1:0]             count,
	output logic [tkcs_pkg::ID_W-1:0]             rd_tag,
	output logic signed [tkcs_pkg::EL_W-1:0]      rd_score
);
	import tkcs_pkg::*;

	logic signed [EL_W-1:0] best_s_q [MAX_K];
	logic [ID_W-1:0]        best_t_q [MAX_K];
	logic [KC_W-1:0]        cnt_q;
	logic [KC_W-1:0]        p, top, lim;
	logic                   take;

	assign lim = KC_W'(ctl.limit);

	always_comb begin
		p = cnt_q;
		for (int j = MAX_K - 1; j >= 0; j--) begin
			if (KC_W'(j) < cnt_q && best_s_q[j] < score)
				p = KC_W'(j);
		end
		top  = (cnt_q < lim) ? cnt_q : lim - KC_W'(1);
		take = ctl.ins && (p < lim);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (p == '0) begin
				best_s_q[0] <= score;
				best_t_q[0] <= tag;
			end
			for (int i = 1; i < MAX_K; i++) begin
				if (KC_W'(i) == p) begin
					best_s_q[i] <= score;
					best_t_q[i] <= tag;
				end else if (KC_W'(i) > p && KC_W'(i) <= top) begin
					best_s_q[i] <= best_s_q[i-1];
					best_t_q[i] <= best_t_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clr) begin
			cnt_q <= '0;
		end else if (take && cnt_q < lim) begin
			cnt_q <= cnt_q + KC_W'(1);
		end
	end

	assign count    = cnt_q;
	assign rd_tag   = best_t_q[rd_idx];
	assign rd_score = best_s_q[rd_idx];

endmodule

[rtl/top_k_cosine_vector_search.sv]
// Top level of the top-k cosine vector search: sequencer, tag store, active marks, result register
//
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_t: opcode, entry_id, element, result_limit
// rsp      out  rsp_valid/rsp_stall  rsp_t: status, match_id, similarity, rank, last_result
// apb      in   psel/penable/pready  vector_length at byte address 0
//
// Element items that do not close a vector transfer one per cycle.
// Closing insert: status sent via T_RESP. Remove: tag store scan, read and compare per used slot.
// Query: active slots are scored in the score unit (multiply and root skipped when a norm is zero),
// inactive slots are passed over, then the results go out in rank order, best first.
// Reset clears the active marks at once; no clearing pass. rsp_stall holds the result register.
module top_k_cosine_vector_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  tkcs_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output tkcs_pkg::rsp_t                rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tkcs_pkg::CFG_AW-1:0]   paddr,
	input  logic [tkcs_pkg::CFG_DW-1:0]   pwdata,
	output logic [tkcs_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready
);
	import tkcs_pkg::*;

	top_state_t state_q, state_d;

	logic [LEN_W-1:0]  vlen_q;
	logic [DIM_W-1:0]  pos_q;
	logic [ID_W-1:0]   ptag_q;
	logic [CNT_W-1:0]  slots_q;
	logic              active_q [CAPACITY];
	logic [ID_W-1:0]   tag_mem [CAPACITY];
	logic [ID_W-1:0]   tag_rd_q;
	logic [CNT_W-1:0]  scan_q;
	logic [ID_W-1:0]   rm_id_q;
	logic [LIM_W-1:0]  limit_q;
	logic [KC_W-1:0]   idx_q;
	rsp_t              resp_q, resp_d;
	rsp_t              rsp_q, out_d;
	logic              rsp_valid_q;

	logic              accept, slot_free, closing, full, scan_end, last;
	logic [LEN_W-1:0]  len_eff;
	logic [LIM_W-1:0]  lim_eff;
	logic [ID_W-1:0]   ptag_new;
	logic [SLOT_W-1:0] scan_idx;
	logic              tag_we, rm_hit, resp_ld, out_load, scan_clr, scan_inc, idx_clr;
	elem_wr_t          ewr;
	score_req_t        sreq;
	topk_ctl_t         tk;
	logic              sc_done;
	logic signed [EL_W-1:0] sc_score, tk_score;
	logic [ID_W-1:0]   tk_tag;
	logic [KC_W-1:0]   tk_count;
	logic              cfg_we;

	// configuration
	assign cfg_we = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_VLEN);
	assign prdata = (paddr[CFG_AW-1] == REG_VLEN) ? CFG_DW'(vlen_q) : '0;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= LEN_W'(MAX_DIM);
		end else if (cfg_we) begin
			vlen_q <= pwdata[LEN_W-1:0];
		end
	end

	always_comb begin
		if (vlen_q == '0)
			len_eff = LEN_W'(1);
		else if (vlen_q > LEN_W'(MAX_DIM))
			len_eff = LEN_W'(MAX_DIM);
		else
			len_eff = vlen_q;
		if (req.result_limit == '0)
			lim_eff = LIM_W'(1);
		else if (req.result_limit > LIM_W'(MAX_K))
			lim_eff = LIM_W'(MAX_K);
		else
			lim_eff = req.result_limit;
	end

	assign accept    = req_valid && (state_q == T_IDLE);
	assign req_stall = (state_q != T_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign closing   = (LEN_W'(pos_q) + LEN_W'(1)) >= len_eff;
	assign full      = slots_q >= CNT_W'(CAPACITY);
	assign ptag_new  = (pos_q == '0) ? req.entry_id : ptag_q;
	assign scan_idx  = scan_q[SLOT_W-1:0];
	assign scan_end  = scan_q >= slots_q;
	assign last      = (idx_q + KC_W'(1)) == tk_count;

	always_comb begin
		ewr.en    = accept && (req.opcode == OP_INSERT || req.opcode == OP_QUERY);
		ewr.store = !full;
		ewr.slot  = slots_q[SLOT_W-1:0];
		ewr.pos   = pos_q;
		ewr.data  = req.element;
	end

	assign tag_we = accept && req.opcode == OP_INSERT && closing && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		resp_ld    = 1'b0;
		resp_d     = '0;
		out_load   = 1'b0;
		out_d      = '0;
		rm_hit     = 1'b0;
		scan_clr   = 1'b0;
		scan_inc   = 1'b0;
		idx_clr    = 1'b0;
		sreq.start = 1'b0;
		sreq.slot  = scan_idx;
		sreq.len   = len_eff;
		tk.clr     = 1'b0;
		tk.ins     = 1'b0;
		tk.limit   = limit_q;
		unique case (state_q)
			T_IDLE: begin
				if (accept) begin
					unique case (req.opcode) inside
						OP_REMOVE: begin
							scan_clr = 1'b1;
							state_d  = T_RM_RD;
						end
						OP_INSERT, OP_QUERY: begin
							if (closing && req.opcode == OP_INSERT) begin
								resp_ld = 1'b1;
								resp_d.status      = full ? STS_FULL : STS_INSERTED;
								resp_d.match_id    = ptag_new;
								resp_d.last_result = 1'b1;
								state_d = T_RESP;
							end else if (closing) begin
								tk.clr   = 1'b1;
								scan_clr = 1'b1;
								state_d  = T_Q_NEXT;
							end
						end
						default: ;
					endcase
				end
			end
			T_RESP: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_d    = resp_q;
					state_d  = T_IDLE;
				end
			end
			T_RM_RD: begin
				if (scan_end) begin
					resp_ld = 1'b1;
					resp_d.status      = STS_NOT_FOUND;
					resp_d.match_id    = rm_id_q;
					resp_d.last_result = 1'b1;
					state_d = T_RESP;
				end else begin
					state_d = T_RM_CMP;
				end
			end
			T_RM_CMP: begin
				if (tag_rd_q == rm_id_q) begin
					rm_hit  = 1'b1;
					resp_ld = 1'b1;
					resp_d.status      = STS_REMOVED;
					resp_d.match_id    = rm_id_q;
					resp_d.last_result = 1'b1;
					state_d = T_RESP;
				end else begin
					scan_inc = 1'b1;
					state_d  = T_RM_RD;
				end
			end
			T_Q_NEXT: begin
				if (scan_end) begin
					if (tk_count == '0) begin
						resp_ld = 1'b1;
						resp_d.status      = STS_EMPTY;
						resp_d.last_result = 1'b1;
						state_d = T_RESP;
					end else begin
						idx_clr = 1'b1;
						state_d = T_EMIT;
					end
				end else if (active_q[scan_idx]) begin
					sreq.start = 1'b1;
					state_d    = T_Q_SCORE;
				end else begin
					scan_inc = 1'b1;
				end
			end
			T_Q_SCORE: begin
				if (sc_done) begin
					tk.ins   = 1'b1;
					scan_inc = 1'b1;
					state_d  = T_Q_NEXT;
				end
			end
			T_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_d.status      = STS_MATCH;
					out_d.match_id    = tk_tag;
					out_d.similarity  = tk_score;
					out_d.rank        = RANK_W'(idx_q);
					out_d.last_result = last;
					if (last)
						state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	// tag store: one write port, registered read at the scan pointer
	always_ff @(posedge clk) begin
		if (tag_we)
			tag_mem[slots_q[SLOT_W-1:0]] <= ptag_new;
		tag_rd_q <= tag_mem[scan_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++)
				active_q[i] <= 1'b0;
			slots_q <= '0;
			pos_q   <= '0;
			ptag_q  <= '0;
		end else begin
			if (tag_we) begin
				active_q[slots_q[SLOT_W-1:0]] <= 1'b1;
				slots_q <= slots_q + CNT_W'(1);
			end
			if (rm_hit)
				active_q[scan_idx] <= 1'b0;
			if (ewr.en) begin
				ptag_q <= ptag_new;
				pos_q  <= closing ? '0 : pos_q + DIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_clr)
			scan_q <= '0;
		else if (scan_inc)
			scan_q <= scan_q + CNT_W'(1);
		if (accept && req.opcode == OP_REMOVE)
			rm_id_q <= req.entry_id;
		if (accept && req.opcode == OP_QUERY && closing)
			limit_q <= lim_eff;
		if (resp_ld)
			resp_q <= resp_d;
		if (idx_clr)
			idx_q <= '0;
		else if (out_load && state_q == T_EMIT)
			idx_q <= idx_q + KC_W'(1);
		if (out_load)
			rsp_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= out_load || (rsp_valid_q && rsp_stall);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	tkcs_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ewr),
		.sreq   (sreq),
		.done   (sc_done),
		.score  (sc_score)
	);

	tkcs_topk u_topk (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tk),
		.score    (sc_score),
		.tag      (tag_rd_q),
		.rd_idx   (idx_q[K_W-1:0]),
		.count    (tk_count),
		.rd_tag   (tk_tag),
		.rd_score (tk_score)
	);

endmodule

[rtl/tkcs_checker.sv]
// Port-level assertions for the top-k cosine vector search, bound to the top level
module tkcs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input tkcs_pkg::req_t              req,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input tkcs_pkg::rsp_t              rsp
);
	import tkcs_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STS_MATCH |->
			rsp.last_result && rsp.rank == '0 && rsp.similarity == '0)
		else $error("non-match result not a lone final transfer");

	a_empty_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_EMPTY |-> rsp.match_id == '0)
		else $error("empty result carries an id");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_MATCH && !rsp.last_result |-> req_stall)
		else $error("input taken while match list still pending");

endmodule

bind top_k_cosine_vector_search tkcs_checker u_tkcs_checker (.*);
